FILE: sv/pir_pkg.sv
// Package for the photometric interaction row block: item types, constants, rounding.
`timescale 1ns / 1ps

package pir_pkg;

    // Configuration port
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_INV_DEPTH = 1'b0;           // register index, paddr[2]
    localparam logic [15:0] INV_DEPTH_RST = 16'd4096; // 1.0 in Q4.12

    // Accumulator width for rounding; every entry stays well below 2^59
    localparam int unsigned ACC_W = 60;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Fraction bits dropped when going to Q24.8
    localparam int unsigned SH_V  = 12;  // Q.20
    localparam int unsigned SH_VZ = 26;  // Q.34
    localparam int unsigned SH_W  = 28;  // Q.36
    localparam int unsigned SH_WZ = 14;  // Q.22

    typedef struct packed {
        logic signed [23:0] grad_x;
        logic signed [23:0] grad_y;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic               last_pixel;
    } pir_in_t;

    typedef struct packed {
        logic signed [31:0] rate_vx;
        logic signed [31:0] rate_vy;
        logic signed [31:0] rate_vz;
        logic signed [31:0] rate_wx;
        logic signed [31:0] rate_wy;
        logic signed [31:0] rate_wz;
        logic               last_row;
    } pir_out_t;

    // Round to nearest (ties up) by dropping sh bits, then clip to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] v,
                                                     input int unsigned sh);
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] r;
        t = (ACC_W+1)'(v) + ((ACC_W+1)'(1) << (sh - 1));
        r = t >>> sh;
        if ((&r[ACC_W:31]) || !(|r[ACC_W:31])) begin
            return r[31:0];
        end else if (r[ACC_W]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

endpackage

FILE: sv/pir_cfg.sv
// APB register bank holding the inverse depth.
`timescale 1ns / 1ps

module pir_cfg
    import pir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [15:0]       inv_depth
);

    logic [15:0] inv_depth_reg;
    logic [15:0] inv_depth_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_INV_DEPTH);

    always_comb begin
        inv_depth_next = inv_depth_reg;
        if (wr_en) begin
            inv_depth_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_depth_reg <= INV_DEPTH_RST;
        end else begin
            inv_depth_reg <= inv_depth_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INV_DEPTH: prdata = {16'd0, inv_depth_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign inv_depth = inv_depth_reg;

endmodule

FILE: sv/pir_pipe.sv
// Five-stage multiply, sum and round pipeline producing one matrix row per item.
`timescale 1ns / 1ps

module pir_pipe
    import pir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] inv_depth,
    input  logic        s_valid,
    output logic        s_ready,
    input  pir_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pir_out_t    m_data
);

    logic               en;
    logic signed [16:0] zi;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;

    // stage 1: coordinate products, gradient-by-coordinate and gradient-by-inverse-depth products
    logic signed [23:0] gx1_reg, gy1_reg;
    logic signed [31:0] xy1_reg, xx1_reg, yy1_reg;
    logic signed [39:0] px1_reg, py1_reg, pzx1_reg, pzy1_reg;
    logic signed [40:0] vxp1_reg, vyp1_reg;
    logic               last1_reg;

    // stage 2: projection and wz sums, the four wide products
    logic signed [23:0] gx2_reg, gy2_reg;
    logic signed [40:0] proj2_reg, wz2_reg, vxp2_reg, vyp2_reg;
    logic signed [55:0] ma2_reg, mb2_reg, mc2_reg, md2_reg;
    logic               last2_reg;

    // stage 3: proj*zi in two halves, wx/wy sums, round vx, vy, wz
    logic signed [40:0] hiz3_reg;
    logic        [32:0] loz3_reg;
    logic signed [57:0] wx3_reg, wy3_reg;
    logic signed [31:0] vx3_reg, vy3_reg, wz3_reg;
    logic               last3_reg;

    // stage 4: vz sum, round wx and wy
    logic signed [58:0] vz4_reg;
    logic signed [31:0] vx4_reg, vy4_reg, wz4_reg, wx4_reg, wy4_reg;
    logic               last4_reg;

    // stage 5: round vz, output register
    pir_out_t out_reg;

    // whole pipeline moves together; a bubble at the end frees it
    assign en      = m_ready || !v5_reg;
    assign s_ready = en;
    assign zi      = $signed({1'b0, inv_depth});

    assign v1_next = en ? s_valid : v1_reg;
    assign v2_next = en ? v1_reg  : v2_reg;
    assign v3_next = en ? v2_reg  : v3_reg;
    assign v4_next = en ? v3_reg  : v4_reg;
    assign v5_next = en ? v4_reg  : v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            gx1_reg   <= s_data.grad_x;
            gy1_reg   <= s_data.grad_y;
            xy1_reg   <= s_data.coord_x * s_data.coord_y;
            xx1_reg   <= s_data.coord_x * s_data.coord_x;
            yy1_reg   <= s_data.coord_y * s_data.coord_y;
            px1_reg   <= s_data.coord_x * s_data.grad_x;
            py1_reg   <= s_data.coord_y * s_data.grad_y;
            pzx1_reg  <= s_data.grad_y * s_data.coord_x;
            pzy1_reg  <= s_data.grad_x * s_data.coord_y;
            vxp1_reg  <= s_data.grad_x * zi;
            vyp1_reg  <= s_data.grad_y * zi;
            last1_reg <= s_data.last_pixel;

            // stage 2
            gx2_reg   <= gx1_reg;
            gy2_reg   <= gy1_reg;
            proj2_reg <= 41'(px1_reg) + 41'(py1_reg);
            wz2_reg   <= 41'(pzx1_reg) - 41'(pzy1_reg);
            ma2_reg   <= gx1_reg * xy1_reg;
            mb2_reg   <= gy1_reg * yy1_reg;
            mc2_reg   <= gx1_reg * xx1_reg;
            md2_reg   <= gy1_reg * xy1_reg;
            vxp2_reg  <= vxp1_reg;
            vyp2_reg  <= vyp1_reg;
            last2_reg <= last1_reg;

            // stage 3: the constant 1 sits at bit 28 of the x*y scale
            hiz3_reg  <= $signed(proj2_reg[40:17]) * zi;
            loz3_reg  <= proj2_reg[16:0] * inv_depth;
            wx3_reg   <= -(58'(ma2_reg) + 58'(mb2_reg) + (58'(gy2_reg) <<< 28));
            wy3_reg   <= 58'(mc2_reg) + 58'(md2_reg) + (58'(gx2_reg) <<< 28);
            vx3_reg   <= round_sat(ACC_W'(vxp2_reg), SH_V);
            vy3_reg   <= round_sat(ACC_W'(vyp2_reg), SH_V);
            wz3_reg   <= round_sat(ACC_W'(wz2_reg), SH_WZ);
            last3_reg <= last2_reg;

            // stage 4
            vz4_reg   <= -((59'(hiz3_reg) <<< 17) + 59'($signed({1'b0, loz3_reg})));
            wx4_reg   <= round_sat(ACC_W'(wx3_reg), SH_W);
            wy4_reg   <= round_sat(ACC_W'(wy3_reg), SH_W);
            vx4_reg   <= vx3_reg;
            vy4_reg   <= vy3_reg;
            wz4_reg   <= wz3_reg;
            last4_reg <= last3_reg;

            // stage 5
            out_reg.rate_vx  <= vx4_reg;
            out_reg.rate_vy  <= vy4_reg;
            out_reg.rate_vz  <= round_sat(ACC_W'(vz4_reg), SH_VZ);
            out_reg.rate_wx  <= wx4_reg;
            out_reg.rate_wy  <= wy4_reg;
            out_reg.rate_wz  <= wz4_reg;
            out_reg.last_row <= last4_reg;
        end
    end

    assign m_valid = v5_reg;
    assign m_data  = out_reg;

endmodule

FILE: sv/photometric_interaction_row_top.sv
// Top level of the photometric interaction row generator.
// One pixel enters per clock unless the pipeline stalls, and its six-entry interaction
// row (Q24.8, saturated) passes through the multiply, sum and round pipeline,
// whose deepest stage holds the 24-by-32-bit products of the gradients
// with x*y, x*x and y*y. A stall on the result side holds all five stages at once;
// only an empty output stage lets the pipeline advance while the result side stalls.
// The inverse depth is to be written over APB at address 0 only while no pixel is in
// flight; the block itself does not enforce this. It resets to 1.0.
`timescale 1ns / 1ps

module photometric_interaction_row_top
    import pir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  pir_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pir_out_t          m_data
);

    logic [15:0] inv_depth;

    pir_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .inv_depth (inv_depth)
    );

    pir_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .inv_depth (inv_depth),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: sv/pir_checker.sv
// Port-level checks for the interaction row block, bound to the top level.
`timescale 1ns / 1ps

module pir_checker
    import pir_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input pir_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input pir_out_t m_data
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a result only goes away when taken
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without handshake");

    // an open output never blocks the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is open");

    // with the output open, an accepted item comes out of the pipeline with its last flag
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid && (m_data.last_row == $past(s_data.last_pixel, 5)))
        else $error("item missing or flag mismatch at pipeline exit");

endmodule

bind photometric_interaction_row_top pir_checker u_pir_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
